// ===== sv/heatmap_cell_colormap_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Heatmap colormap assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef HEATMAP_CELL_COLORMAP_UNIT_MACROS_SVH
`define HEATMAP_CELL_COLORMAP_UNIT_MACROS_SVH

// same-cycle implication
`define HCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Heatmap colormap package
// Shared constants, configuration register map and configuration struct.
// ----------------------------------------------------------------------------
package hcc_pkg;

    // default sizes
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_SIDE_DEF    = 256;
    localparam int QUEUE_DEPTH     = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MINIMUM    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_SCALE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LAST_INDEX = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT      = 3'd7;

    // input word opcodes
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_SAMPLE      = 1'b1;

    // largest x position, unsigned Q15.16
    localparam logic [30:0] POSX_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [8:0]         grid_columns;
        logic [8:0]         grid_rows;
        logic signed [31:0] value_minimum;
        logic [31:0]        value_scale;
        logic [7:0]         table_last_index;
        logic [30:0]        cell_width;
        logic [30:0]        cell_height;
        logic [30:0]        plot_height;
    } t_cfg;

endpackage

// ===== sv/hcc_if.sv =====
// ----------------------------------------------------------------------------
// Heatmap colormap stream interfaces
// Valid/ready channels for the input word and the result word.
// ----------------------------------------------------------------------------
interface hcc_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [7:0]         table_address;
    logic [31:0]        table_color;
    logic signed [31:0] sample;
    logic               sample_finite;

    modport source (output valid, op, table_address, table_color, sample, sample_finite,
                    input ready);
    modport sink (input valid, op, table_address, table_color, sample, sample_finite,
                  output ready);
endinterface

interface hcc_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        cell_number;
    logic [7:0]         cell_column;
    logic [7:0]         cell_row;
    logic [30:0]        pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        cell_color;

    modport source (output valid, cell_number, cell_column, cell_row, pos_x, pos_y,
                    cell_color, input ready);
    modport sink (input valid, cell_number, cell_column, cell_row, pos_x, pos_y,
                  cell_color, output ready);
endinterface

// ===== sv/hcc_front.sv =====
// ----------------------------------------------------------------------------
// Heatmap colormap front end
// Accepts input words, tracks the grid cell counter, drops skipped values
// and packs table writes and lookups into jobs for the queue.
// ----------------------------------------------------------------------------
module hcc_front import hcc_pkg::*; #(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cfg                             i_cfg,
    hcc_in_if.sink                           i_in,
    input  logic                             i_full,
    output logic                             o_push,
    output logic [1+8+32+16+2*$clog2(MAX_SIDE)-1:0] o_job
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int LW = CW + 1;

    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_row, n_row;
    logic [15:0]   r_num, n_num;

    logic               accept;
    logic               is_sample;
    logic               keep;
    logic [LW-1:0]      cols;
    logic [LW-1:0]      rows;
    logic               col_wrap;
    logic               row_wrap;
    logic signed [32:0] diff;
    logic [31:0]        arg;

    // clamp a grid side to 1..MAX_SIDE
    function automatic logic [LW-1:0] side_limit(input logic [8:0] v);
        logic [LW-1:0] r;
        if (v == 9'd0) begin
            r = LW'(1);
        end else if (32'(v) > 32'(MAX_SIDE)) begin
            r = LW'(MAX_SIDE);
        end else begin
            r = LW'(v);
        end
        return r;
    endfunction

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign is_sample  = (i_in.op == OP_SAMPLE);

    // cell counter
    assign cols     = side_limit(i_cfg.grid_columns);
    assign rows     = side_limit(i_cfg.grid_rows);
    assign col_wrap = ({1'b0, r_col} + LW'(1)) >= cols;
    assign row_wrap = ({1'b0, r_row} + LW'(1)) >= rows;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_num = r_num;
        if (accept && is_sample) begin
            if (col_wrap) begin
                n_col = '0;
                if (row_wrap) begin
                    n_row = '0;
                    n_num = '0;
                end else begin
                    n_row = r_row + CW'(1);
                    n_num = r_num + 16'd1;
                end
            end else begin
                n_col = r_col + CW'(1);
                n_num = r_num + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_num <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_num <= n_num;
        end
    end

    // classify: table writes always go on, samples only when finite and above min
    assign diff = {i_in.sample[31], i_in.sample}
                - {i_cfg.value_minimum[31], i_cfg.value_minimum};
    assign keep = !is_sample || (i_in.sample_finite && !diff[32] && (diff != 33'sd0));
    assign arg  = is_sample ? diff[31:0] : i_in.table_color;

    assign o_push = accept && keep;
    assign o_job  = {i_in.op, i_in.table_address, arg, r_num, r_col, r_row};

endmodule

// ===== sv/hcc_queue.sv =====
// ----------------------------------------------------------------------------
// Heatmap colormap job queue
// Short FIFO between front and back end so each side can stall on its own.
// ----------------------------------------------------------------------------
`include "heatmap_cell_colormap_unit_macros.svh"

module hcc_queue import hcc_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [AW:0]      r_count, n_count;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (pop && !push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `HCC_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= (AW+1)'(DEPTH), "queue fill count beyond depth")
    `HCC_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + (AW+1)'(1), "queue count missed a push")
    `HCC_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !push && !pop, $stable(r_count) && $stable(r_rptr), "queue moved while idle")

endmodule

// ===== sv/hcc_back.sv =====
// ----------------------------------------------------------------------------
// Heatmap colormap back end
// Three-stage pipeline: multiply, round/clamp with table access, result.
// Holds the color table; writes and lookups meet it in stream order.
// ----------------------------------------------------------------------------
module hcc_back import hcc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_SIDE    = MAX_SIDE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cfg                             i_cfg,
    input  logic                             i_job_valid,
    input  logic [1+8+32+16+2*$clog2(MAX_SIDE)-1:0] i_job,
    output logic                             o_pop,
    hcc_out_if.source                        o_out
);

    localparam int CW  = $clog2(MAX_SIDE);
    localparam int TW  = $clog2(TABLE_DEPTH);
    localparam int PXW = CW + 31;
    localparam int PYW = CW + 32;

    logic en;

    // stage 1: job register
    logic          r_s1_v;
    logic          r_s1_op;
    logic [7:0]    r_s1_addr;
    logic [31:0]   r_s1_arg;
    logic [15:0]   r_s1_num;
    logic [CW-1:0] r_s1_col;
    logic [CW-1:0] r_s1_row;
    logic [CW:0]   s1_row_p1;

    // stage 2: products
    logic           r_s2_v;
    logic           r_s2_op;
    logic [7:0]     r_s2_addr;
    logic [31:0]    r_s2_arg;
    logic [15:0]    r_s2_num;
    logic [CW-1:0]  r_s2_col;
    logic [CW-1:0]  r_s2_row;
    logic [63:0]    r_s2_prod;
    logic [PXW-1:0] r_s2_px;
    logic [PYW-1:0] r_s2_py;

    logic [64:0]    s2_rnd;
    logic [32:0]    s2_idx;
    logic [TW-1:0]  s2_last;
    logic [TW-1:0]  s2_ridx;
    logic           s2_wr_ok;
    logic [30:0]    s2_px;
    logic [PYW:0]   s2_pyd;
    logic [31:0]    s2_py;

    // stage 3: result register
    logic          r_s3_v;
    logic [15:0]   r_s3_num;
    logic [CW-1:0] r_s3_col;
    logic [CW-1:0] r_s3_row;
    logic [30:0]   r_s3_px;
    logic [31:0]   r_s3_py;
    logic [31:0]   r_s3_color;

    logic [31:0]   r_table [TABLE_DEPTH];

    // whole pipeline moves unless the result is stalled
    assign en    = !r_s3_v || o_out.ready;
    assign o_pop = en && i_job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_job_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v && (r_s2_op == OP_SAMPLE);
        end
    end

    // stage 1 load
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r_s1_op, r_s1_addr, r_s1_arg, r_s1_num, r_s1_col, r_s1_row} <= i_job;
        end
    end

    // stage 1 -> 2: index product and position products
    assign s1_row_p1 = {1'b0, r_s1_row} + (CW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_op   <= r_s1_op;
            r_s2_addr <= r_s1_addr;
            r_s2_arg  <= r_s1_arg;
            r_s2_num  <= r_s1_num;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_prod <= 64'(r_s1_arg) * 64'(i_cfg.value_scale);
            r_s2_px   <= PXW'(r_s1_col) * PXW'(i_cfg.cell_width);
            r_s2_py   <= PYW'(s1_row_p1) * PYW'(i_cfg.cell_height);
        end
    end

    // stage 2: round half up, clamp to last index
    assign s2_rnd  = {1'b0, r_s2_prod} + 65'h0_8000_0000;
    assign s2_idx  = s2_rnd[64:32];
    assign s2_last = (32'(i_cfg.table_last_index) >= 32'(TABLE_DEPTH))
                   ? TW'(TABLE_DEPTH - 1) : TW'(i_cfg.table_last_index);
    assign s2_ridx = (s2_idx > 33'(s2_last)) ? s2_last : TW'(s2_idx);
    assign s2_wr_ok = 32'(r_s2_addr) < 32'(TABLE_DEPTH);

    // stage 2: saturate positions
    assign s2_px  = (r_s2_px > PXW'(POSX_MAX)) ? POSX_MAX : r_s2_px[30:0];
    assign s2_pyd = (PYW+1)'(i_cfg.plot_height) - {1'b0, r_s2_py};
    assign s2_py  = (s2_pyd[PYW] && !(&s2_pyd[PYW:31])) ? 32'h8000_0000 : s2_pyd[31:0];

    // color table: write or registered read, in stream order
    always_ff @(posedge i_clk) begin
        if (en && r_s2_v) begin
            if (r_s2_op == OP_TABLE_WRITE) begin
                if (s2_wr_ok) begin
                    r_table[TW'(r_s2_addr)] <= r_s2_arg;
                end
            end else begin
                r_s3_color <= r_table[s2_ridx];
            end
        end
    end

    // stage 3 load
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_num <= r_s2_num;
            r_s3_col <= r_s2_col;
            r_s3_row <= r_s2_row;
            r_s3_px  <= s2_px;
            r_s3_py  <= s2_py;
        end
    end

    assign o_out.valid       = r_s3_v;
    assign o_out.cell_number = r_s3_num;
    assign o_out.cell_column = 8'(r_s3_col);
    assign o_out.cell_row    = 8'(r_s3_row);
    assign o_out.pos_x       = r_s3_px;
    assign o_out.pos_y       = r_s3_py;
    assign o_out.cell_color  = r_s3_color;

endmodule

// ===== sv/heatmap_cell_colormap_unit.sv =====
// ----------------------------------------------------------------------------
// Heatmap cell colormap unit
// Path: a grid value's result word is valid after passing the queue write,
//   job, product and result registers.
// Throughput: one word per cycle unless the queue is full; table port and
//   multipliers take one word a cycle; a 4-entry queue absorbs output stalls.
// Reset: synchronous active low; clears the cell counter, queue and pipeline
//   valids and loads config defaults. The color table is not cleared.
// ----------------------------------------------------------------------------
module heatmap_cell_colormap_unit import hcc_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_SIDE    = MAX_SIDE_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    hcc_in_if.sink                i_in,
    hcc_out_if.source             o_out
);

    localparam int JW = 1 + 8 + 32 + 16 + 2 * $clog2(MAX_SIDE);

    t_cfg          r_cfg;
    logic          push;
    logic [JW-1:0] push_job;
    logic          full;
    logic          pop;
    logic          job_valid;
    logic [JW-1:0] job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_columns     <= 9'd1;
            r_cfg.grid_rows        <= 9'd1;
            r_cfg.value_minimum    <= 32'sd0;
            r_cfg.value_scale      <= 32'd65536;
            r_cfg.table_last_index <= 8'd255;
            r_cfg.cell_width       <= 31'd65536;
            r_cfg.cell_height      <= 31'd65536;
            r_cfg.plot_height      <= 31'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_COLUMNS:     r_cfg.grid_columns     <= i_cfg_wdata[8:0];
                CFG_GRID_ROWS:        r_cfg.grid_rows        <= i_cfg_wdata[8:0];
                CFG_VALUE_MINIMUM:    r_cfg.value_minimum    <= i_cfg_wdata;
                CFG_VALUE_SCALE:      r_cfg.value_scale      <= i_cfg_wdata;
                CFG_TABLE_LAST_INDEX: r_cfg.table_last_index <= i_cfg_wdata[7:0];
                CFG_CELL_WIDTH:       r_cfg.cell_width       <= i_cfg_wdata[30:0];
                CFG_CELL_HEIGHT:      r_cfg.cell_height      <= i_cfg_wdata[30:0];
                CFG_PLOT_HEIGHT:      r_cfg.plot_height      <= i_cfg_wdata[30:0];
                default: begin
                end
            endcase
        end
    end

    hcc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (push_job)
    );

    hcc_queue #(
        .WIDTH (JW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (job_valid),
        .o_data  (job)
    );

    hcc_back #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_SIDE    (MAX_SIDE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
